FILE: rtl/core/phantom_intention_lock_table_top_macros.svh
// Assertion macros for the phantom intention lock table checker.
// No dependencies; included by the checker file.
`ifndef PHANTOM_INTENTION_LOCK_TABLE_TOP_MACROS_SVH
`define PHANTOM_INTENTION_LOCK_TABLE_TOP_MACROS_SVH

// Clocked assertion with async active-low reset disable.
`define PILT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Shorthand for the top level clock and reset names.
`define PILT_ASSERT(lbl, prop, msg) \
  `PILT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/core/pilt_pkg.sv
// Shared types, constants and codes for the phantom intention lock table.
// No dependencies; imported by every module of the block.
`default_nettype none

package pilt_pkg;

  localparam int unsigned LOCK_ENTRIES      = 1024;
  localparam int unsigned SHARED_COUNT_BITS = 16;
  localparam int unsigned IX_COUNT_BITS     = 15;

  localparam int unsigned LOCK_AW  = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned SH_W     = 16;
  localparam int unsigned IX_W     = 15;
  localparam int unsigned STATUS_W = 2;

  localparam logic [SH_W-1:0] SH_MAX = SH_W'((33'd1 << SHARED_COUNT_BITS) - 33'd1);
  localparam logic [IX_W-1:0] IX_MAX = IX_W'((33'd1 << IX_COUNT_BITS) - 33'd1);

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABORT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WAIT     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD = 2'd3;

  localparam logic OP_ACQUIRE  = 1'b0;
  localparam logic OP_RELEASE  = 1'b1;
  localparam logic MODE_SHARED = 1'b0;
  localparam logic MODE_IX     = 1'b1;

  typedef struct packed {
    logic               operation;
    logic               lock_mode;
    logic [INDEX_W-1:0] lock_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SH_W-1:0]     shared_count;
    logic [IX_W-1:0]     ix_count;
    logic                shared_waiting;
  } rsp_t;

  typedef struct packed {
    logic            waiting;
    logic [IX_W-1:0] ix;
    logic [SH_W-1:0] sh;
  } lock_word_t;

  typedef struct packed {
    logic clr_we;
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/pilt_ctrl.sv
// Controller FSM: clearing pass, request capture and commit sequencing.
// Depends on pilt_pkg.
`default_nettype none

module pilt_ctrl import pilt_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  wire  out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/pilt_datapath.sv
// Datapath: lock word memory, clear counter, update logic and result register.
// Depends on pilt_pkg.
`default_nettype none

module pilt_datapath import pilt_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  input  req_t in_req_i,
  output rsp_t out_rsp_o
);

  lock_word_t lock_mem [LOCK_ENTRIES];

  logic [LOCK_AW-1:0] clr_addr_q;
  req_t               req_q;
  lock_word_t         rdata_q;
  rsp_t               rsp_q;

  lock_word_t         word_d;
  logic [STATUS_W-1:0] status_d;
  logic               in_range;
  logic               mem_we;
  logic [LOCK_AW-1:0] mem_waddr;
  lock_word_t         mem_wdata;

  assign in_range = (32'(req_q.lock_index) < LOCK_ENTRIES);

  always_comb begin
    word_d   = rdata_q;
    status_d = ST_OK;
    if (req_q.operation == OP_ACQUIRE) begin
      if (req_q.lock_mode == MODE_IX) begin
        if (rdata_q.waiting || (rdata_q.sh != '0) || (rdata_q.ix >= IX_MAX)) begin
          status_d = ST_ABORT;
        end else begin
          word_d.ix = rdata_q.ix + IX_W'(1);
        end
      end else begin
        if (rdata_q.ix != '0) begin
          word_d.waiting = 1'b1;
          status_d       = ST_WAIT;
        end else if (rdata_q.sh >= SH_MAX) begin
          status_d = ST_ABORT;
        end else begin
          word_d.sh      = rdata_q.sh + SH_W'(1);
          word_d.waiting = 1'b0;
        end
      end
    end else begin
      if (req_q.lock_mode == MODE_IX) begin
        if (rdata_q.ix == '0) begin
          status_d = ST_NOT_HELD;
        end else begin
          word_d.ix = rdata_q.ix - IX_W'(1);
        end
      end else begin
        if (rdata_q.sh == '0) begin
          status_d = ST_NOT_HELD;
        end else begin
          word_d.sh = rdata_q.sh - SH_W'(1);
        end
      end
    end
  end

  assign mem_we    = cmd_i.clr_we || (cmd_i.commit && in_range);
  assign mem_waddr = cmd_i.clr_we ? clr_addr_q : LOCK_AW'(req_q.lock_index);
  assign mem_wdata = cmd_i.clr_we ? '0 : word_d;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lock_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.capture) begin
      rdata_q <= lock_mem[LOCK_AW'(in_req_i.lock_index)];
      req_q   <= in_req_i;
    end
    if (cmd_i.commit) begin
      if (in_range) begin
        rsp_q.status         <= status_d;
        rsp_q.shared_count   <= word_d.sh;
        rsp_q.ix_count       <= word_d.ix;
        rsp_q.shared_waiting <= word_d.waiting;
      end else begin
        rsp_q.status         <= ST_ABORT;
        rsp_q.shared_count   <= '0;
        rsp_q.ix_count       <= '0;
        rsp_q.shared_waiting <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_addr_q <= clr_addr_q + LOCK_AW'(1);
    end
  end

  assign sts_o.clr_last = (clr_addr_q == LOCK_AW'(LOCK_ENTRIES - 1));
  assign out_rsp_o      = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/core/phantom_intention_lock_table_top.sv
// Lock table with intention locks, shared priority: each request is handled
// by a read of the addressed lock word from the single-port table memory, then
// an update that writes it back and loads the result register. A request is
// accepted while a previous result still waits in the result register; its
// update holds until that register is free. After reset the table is cleared
// one word a cycle, all LOCK_ENTRIES (1024) words, with requests stalled.
// Depends on pilt_pkg, pilt_ctrl and pilt_datapath.
`default_nettype none

module phantom_intention_lock_table_top import pilt_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  wire  out_stall_i,
  output rsp_t out_rsp_o
);

  cmd_t cmd;
  sts_t sts;

  pilt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pilt_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_req_i  (in_req_i),
    .out_rsp_o (out_rsp_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/pilt_checker.sv
// Port-level checker for the lock table top level, bound into it below.
// Depends on pilt_pkg and phantom_intention_lock_table_top_macros.svh.
`default_nettype none
`include "phantom_intention_lock_table_top_macros.svh"

module pilt_checker import pilt_pkg::*; (
  input wire  clk_i,
  input wire  rst_ni,
  input wire  in_valid_i,
  input wire  in_stall_o,
  input wire  out_valid_o,
  input wire  out_stall_i,
  input rsp_t out_rsp_o
);

  `PILT_ASSERT(a_out_valid_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `PILT_ASSERT(a_out_rsp_hold, out_valid_o && out_stall_i |=> $stable(out_rsp_o), "stalled result changed")
  `PILT_ASSERT(a_one_at_a_time, in_valid_i && !in_stall_o |=> in_stall_o, "request taken while busy")
  `PILT_ASSERT(a_rsp_from_req, $rose(out_valid_o) |-> $past(in_stall_o), "result without request in flight")

endmodule

bind phantom_intention_lock_table_top pilt_checker u_pilt_checker (.*);

`default_nettype wire
